/* src/binned_net_charge_mean_top_assert.svh */
// Assertion macros for the binned net-charge profile block
`ifndef BINNED_NET_CHARGE_MEAN_TOP_ASSERT_SVH
`define BINNED_NET_CHARGE_MEAN_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BNCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BNCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bncm_pkg.sv */
// Package: constants, codes and state type of the binned net-charge profile block
`default_nettype none

package bncm_pkg;

  localparam int NUM_BINS   = 6;
  localparam int MAX_TRACKS = 255;

  localparam int BIN_IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int BIN_IN_W   = 3;
  localparam int TC_W       = 8;
  localparam int EC_W       = 9;
  localparam int EV_W       = 32;
  localparam int TS_W       = 40;
  localparam int CS_W       = 41;
  localparam int Q_W        = 16;
  localparam int NC_W       = 17;
  localparam int CNT_W      = $clog2(Q_W);
  localparam int REM_W      = EV_W + 1;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PT_W       = 16;
  localparam int ETA_W      = 14;
  localparam int ETAL_W     = 13;
  localparam int BW_W       = 8;

  localparam logic [PT_W-1:0]   PT_THR_RST  = 16'd50;
  localparam logic [ETAL_W-1:0] ETA_LIM_RST = 13'd1024;
  localparam logic [BW_W-1:0]   BIN_W_RST   = 8'd20;

  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_EOE   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PT_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_W   = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_BIN  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_DIVM = 7'b0010000,
    S_DIVC = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

/* src/binned_net_charge_mean_top.sv */
// Top level: per-event multiplicity and net-charge profile over multiplicity bins
//
// Input channel (in_valid / in_stall): one word per track, end of event or bin read.
// Result channel (out_valid / out_stall): one word per bin read, nothing otherwise.
// Config port (cfg_we / cfg_index / cfg_wdata): write pt threshold, eta limit, bin width.
// A track is counted without leaving the idle state, so the next word is taken on the following edge.
// End of event: the bin is found by repeated subtraction of the bin width in S_BIN,
// in the shared compare-subtract unit, then the bin is updated in S_UPD.
// A bin read loads the output register from S_DONE: after S_RD, the same unit runs a
// 16-step restoring divide for the mean multiplicity and again for the mean net charge;
// a missing bin goes straight to S_DONE, and an empty one skips both divides.
// in_stall is high while a word is in progress; a stalled result holds its payload,
// and a following read then waits in its last step with in_stall high.
// Reset clears the config to defaults, the event accumulators and all bins.
`default_nettype none

module binned_net_charge_mean_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [1:0]                           in_mode,
  input  wire  [bncm_pkg::PT_W-1:0]            in_pt,
  input  wire  signed [bncm_pkg::ETA_W-1:0]    in_eta,
  input  wire                                  in_charge_positive,
  input  wire  [bncm_pkg::BIN_IN_W-1:0]        in_bin_index,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 out_bin_valid,
  output logic [bncm_pkg::Q_W-1:0]             out_mean_multiplicity,
  output logic signed [bncm_pkg::NC_W-1:0]     out_mean_net_charge,
  output logic [bncm_pkg::EV_W-1:0]            out_event_count,
  input  wire                                  cfg_we,
  input  wire  [bncm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [bncm_pkg::CFG_W-1:0]           cfg_wdata
);

`include "binned_net_charge_mean_top_assert.svh"

  localparam int NB   = bncm_pkg::NUM_BINS;
  localparam int BIW  = bncm_pkg::BIN_IDX_W;
  localparam int TCW  = bncm_pkg::TC_W;
  localparam int ECW  = bncm_pkg::EC_W;
  localparam int EVW  = bncm_pkg::EV_W;
  localparam int TSW  = bncm_pkg::TS_W;
  localparam int CSW  = bncm_pkg::CS_W;
  localparam int QW   = bncm_pkg::Q_W;
  localparam int NCW  = bncm_pkg::NC_W;
  localparam int CNW  = bncm_pkg::CNT_W;
  localparam int RMW  = bncm_pkg::REM_W;

  bncm_pkg::state_t state_r, state_nxt;

  logic [bncm_pkg::PT_W-1:0]   pt_thr_r;
  logic [bncm_pkg::ETAL_W-1:0] eta_lim_r;
  logic [bncm_pkg::BW_W-1:0]   bin_width_r;

  logic [TCW-1:0]         track_count_r;
  logic signed [ECW-1:0]  event_charge_r;
  logic [EVW-1:0]         bin_events_r [NB];
  logic [TSW-1:0]         bin_track_sum_r [NB];
  logic signed [CSW-1:0]  bin_charge_sum_r [NB];

  logic [RMW-1:0] rem_r;
  logic [EVW-1:0] div_r;
  logic [QW-1:0]  dvd_r;
  logic [CNW-1:0] cnt_r;
  logic [BIW-1:0] bin_r;
  logic           ok_r;
  logic           neg_r;
  logic [QW-1:0]  mm_r;

  logic           out_valid_r;
  logic           out_bin_valid_r;
  logic [QW-1:0]  out_mm_r;
  logic [NCW-1:0] out_nc_r;
  logic [EVW-1:0] out_ev_r;

  // shared compare-subtract unit
  logic [RMW-1:0] sh_a;
  logic [RMW:0]   sub_diff;
  logic           sub_ge;

  logic                       in_acc;
  logic                       out_free;
  logic [bncm_pkg::ETA_W-1:0] eta_abs;
  logic                       charge_pass;
  logic                       bin_bad;
  logic [EVW-1:0]             sel_ev;
  logic [TSW-1:0]             sel_ts;
  logic signed [CSW-1:0]      sel_cs;
  logic [CSW-1:0]             cs_mag;
  logic [NCW-1:0]             q_ext;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != bncm_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid             = out_valid_r;
  assign out_bin_valid         = out_bin_valid_r;
  assign out_mean_multiplicity = out_mm_r;
  assign out_mean_net_charge   = out_nc_r;
  assign out_event_count       = out_ev_r;

  assign sh_a     = (state_r == bncm_pkg::S_BIN) ? rem_r : {rem_r[RMW-2:0], dvd_r[QW-1]};
  assign sub_diff = {1'b0, sh_a} - {2'b00, div_r};
  assign sub_ge   = !sub_diff[RMW];

  assign eta_abs     = in_eta[bncm_pkg::ETA_W-1] ? (~in_eta + 1'b1) : in_eta;
  assign charge_pass = (in_pt > pt_thr_r) && (eta_abs < {1'b0, eta_lim_r});
  assign bin_bad     = ({1'b0, in_bin_index} >= (bncm_pkg::BIN_IN_W + 1)'(NB));

  assign sel_ev = bin_events_r[bin_r];
  assign sel_ts = bin_track_sum_r[bin_r];
  assign sel_cs = bin_charge_sum_r[bin_r];
  assign cs_mag = sel_cs[CSW-1] ? (~sel_cs + 1'b1) : sel_cs;
  assign q_ext  = {1'b0, dvd_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bncm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_mode == bncm_pkg::MODE_EOE) begin
            state_nxt = bncm_pkg::S_BIN;
          end else if (in_mode == bncm_pkg::MODE_READ) begin
            state_nxt = bin_bad ? bncm_pkg::S_DONE : bncm_pkg::S_RD;
          end
        end
      end
      bncm_pkg::S_BIN: begin
        if (!(sub_ge && (bin_r != BIW'(NB - 1)))) begin
          state_nxt = bncm_pkg::S_UPD;
        end
      end
      bncm_pkg::S_UPD: state_nxt = bncm_pkg::S_IDLE;
      bncm_pkg::S_RD: begin
        state_nxt = (sel_ev == '0) ? bncm_pkg::S_DONE : bncm_pkg::S_DIVM;
      end
      bncm_pkg::S_DIVM: begin
        if (cnt_r == CNW'(QW - 1)) begin
          state_nxt = bncm_pkg::S_DIVC;
        end
      end
      bncm_pkg::S_DIVC: begin
        if (cnt_r == CNW'(QW - 1)) begin
          state_nxt = bncm_pkg::S_DONE;
        end
      end
      bncm_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = bncm_pkg::S_IDLE;
        end
      end
      default: state_nxt = bncm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bncm_pkg::S_IDLE;
      pt_thr_r       <= bncm_pkg::PT_THR_RST;
      eta_lim_r      <= bncm_pkg::ETA_LIM_RST;
      bin_width_r    <= bncm_pkg::BIN_W_RST;
      track_count_r  <= '0;
      event_charge_r <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        bin_events_r[i]     <= '0;
        bin_track_sum_r[i]  <= '0;
        bin_charge_sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          bncm_pkg::CFG_PT_THR:  pt_thr_r    <= cfg_wdata[bncm_pkg::PT_W-1:0];
          bncm_pkg::CFG_ETA_LIM: eta_lim_r   <= cfg_wdata[bncm_pkg::ETAL_W-1:0];
          bncm_pkg::CFG_BIN_W:   bin_width_r <= cfg_wdata[bncm_pkg::BW_W-1:0];
          default: ;
        endcase
      end

      if ((state_r == bncm_pkg::S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        bncm_pkg::S_IDLE: begin
          if (in_acc) begin
            if (in_mode == bncm_pkg::MODE_TRACK) begin
              if (track_count_r < TCW'(bncm_pkg::MAX_TRACKS)) begin
                track_count_r <= track_count_r + 1'b1;
                if (charge_pass) begin
                  event_charge_r <= in_charge_positive ? event_charge_r + 1'b1
                                                       : event_charge_r - 1'b1;
                end
              end
            end else if (in_mode == bncm_pkg::MODE_EOE) begin
              rem_r <= {{(RMW - TCW){1'b0}}, track_count_r};
              div_r <= {{(EVW - bncm_pkg::BW_W){1'b0}}, bin_width_r};
              bin_r <= '0;
            end else if (in_mode == bncm_pkg::MODE_READ) begin
              bin_r <= in_bin_index[BIW-1:0];
              ok_r  <= 1'b0;
            end
          end
        end
        bncm_pkg::S_BIN: begin
          if (sub_ge && (bin_r != BIW'(NB - 1))) begin
            rem_r <= sub_diff[RMW-1:0];
            bin_r <= bin_r + 1'b1;
          end
        end
        bncm_pkg::S_UPD: begin
          if (sel_ev != '1) begin
            bin_events_r[bin_r]     <= sel_ev + 1'b1;
            bin_track_sum_r[bin_r]  <= sel_ts + {{(TSW - TCW){1'b0}}, track_count_r};
            bin_charge_sum_r[bin_r] <= sel_cs +
                                       {{(CSW - ECW){event_charge_r[ECW-1]}}, event_charge_r};
          end
          track_count_r  <= '0;
          event_charge_r <= '0;
        end
        bncm_pkg::S_RD: begin
          ok_r  <= (sel_ev != '0);
          div_r <= sel_ev;
          rem_r <= {1'b0, sel_ts[TSW-1 -: EVW]};
          dvd_r <= {sel_ts[7:0], 8'h00};
          cnt_r <= '0;
        end
        bncm_pkg::S_DIVM, bncm_pkg::S_DIVC: begin
          cnt_r <= cnt_r + 1'b1;
          if ((state_r == bncm_pkg::S_DIVM) && (cnt_r == CNW'(QW - 1))) begin
            mm_r  <= {dvd_r[QW-2:0], sub_ge};
            neg_r <= sel_cs[CSW-1];
            rem_r <= {1'b0, cs_mag[CSW-2 -: EVW]};
            dvd_r <= {cs_mag[7:0], 8'h00};
          end else begin
            rem_r <= sub_ge ? sub_diff[RMW-1:0] : sh_a;
            dvd_r <= {dvd_r[QW-2:0], sub_ge};
          end
        end
        bncm_pkg::S_DONE: begin
          if (out_free) begin
            out_bin_valid_r <= ok_r;
            out_mm_r        <= ok_r ? mm_r : '0;
            out_nc_r        <= !ok_r ? '0 : (neg_r ? (~q_ext + 1'b1) : q_ext);
            out_ev_r        <= ok_r ? div_r : '0;
          end
        end
        default: ;
      endcase
    end
  end

  `BNCM_ASSERT_NOW(a_empty_read_zero, out_valid && !out_bin_valid, (out_mean_multiplicity == '0) && (out_event_count == '0), "invalid bin read carries nonzero fields")
  `BNCM_ASSERT_NEXT(a_track_counts, in_acc && (in_mode == bncm_pkg::MODE_TRACK) && (track_count_r < TCW'(bncm_pkg::MAX_TRACKS)), track_count_r == $past(track_count_r) + 1'b1, "accepted track not counted")
  `BNCM_ASSERT_NEXT(a_event_clear, state_r == bncm_pkg::S_UPD, (track_count_r == '0) && (event_charge_r == '0), "event accumulators not cleared after bin update")
  `BNCM_ASSERT_NOW(a_bin_range, state_r == bncm_pkg::S_BIN, bin_r < BIW'(NB), "bin search past top bin")

endmodule

`default_nettype wire

/* bench/binned_net_charge_mean_top_tb.sv */
// Testbench for the binned net-charge profile block: directed table, then random events
`timescale 1ns / 1ps
`default_nettype none

module binned_net_charge_mean_top_tb;

  localparam int NUM_BINS   = bncm_pkg::NUM_BINS;
  localparam int MAX_TRACKS = bncm_pkg::MAX_TRACKS;
  localparam int BIN_IN_W   = bncm_pkg::BIN_IN_W;
  localparam int TC_W       = bncm_pkg::TC_W;
  localparam int EV_W       = bncm_pkg::EV_W;
  localparam int Q_W        = bncm_pkg::Q_W;
  localparam int NC_W       = bncm_pkg::NC_W;
  localparam int CFG_W      = bncm_pkg::CFG_W;
  localparam int CFG_IDX_W  = bncm_pkg::CFG_IDX_W;
  localparam int PT_W       = bncm_pkg::PT_W;
  localparam int ETA_W      = bncm_pkg::ETA_W;
  localparam int ETAL_W     = bncm_pkg::ETAL_W;
  localparam int BW_W       = bncm_pkg::BW_W;

  localparam logic [PT_W-1:0]   PT_THR_RST  = bncm_pkg::PT_THR_RST;
  localparam logic [ETAL_W-1:0] ETA_LIM_RST = bncm_pkg::ETA_LIM_RST;
  localparam logic [BW_W-1:0]   BIN_W_RST   = bncm_pkg::BIN_W_RST;

  localparam logic [1:0] MODE_TRACK = bncm_pkg::MODE_TRACK;
  localparam logic [1:0] MODE_EOE   = bncm_pkg::MODE_EOE;
  localparam logic [1:0] MODE_READ  = bncm_pkg::MODE_READ;

  localparam logic [CFG_IDX_W-1:0] CFG_PT_THR  = bncm_pkg::CFG_PT_THR;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIM = bncm_pkg::CFG_ETA_LIM;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_W   = bncm_pkg::CFG_BIN_W;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic                     bin_valid;
    logic [Q_W-1:0]           mean_mult;
    logic signed [NC_W-1:0]   mean_charge;
    logic [EV_W-1:0]          events;
  } bin_means_t;

  typedef struct {
    logic [1:0]               mode;
    logic [PT_W-1:0]          pt;
    logic signed [ETA_W-1:0]  eta;
    logic                     chg;
    logic [BIN_IN_W-1:0]      bidx;
    bit                       zero_exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_TRACK;
  logic [PT_W-1:0] in_pt = '0;
  logic signed [ETA_W-1:0] in_eta = '0;
  logic in_charge_positive = 1'b0;
  logic [BIN_IN_W-1:0] in_bin_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_bin_valid;
  logic [Q_W-1:0] out_mean_multiplicity;
  logic signed [NC_W-1:0] out_mean_net_charge;
  logic [EV_W-1:0] out_event_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PT_THR;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // profile state mirrored by the bench
  logic [PT_W-1:0] pt_thr = PT_THR_RST;
  logic [ETAL_W-1:0] eta_lim = ETA_LIM_RST;
  logic [BW_W-1:0] bin_wd = BIN_W_RST;
  logic [TC_W-1:0] trk_cnt = '0;
  int evt_charge = 0;
  logic [EV_W-1:0] bin_ev [NUM_BINS];
  logic [63:0] bin_trk [NUM_BINS];
  longint bin_chg [NUM_BINS];

  bin_means_t pending_means[$];
  stim_row_t dir_rows[$];

  int fail_count = 0;
  int cycle_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  binned_net_charge_mean_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_pt(in_pt),
    .in_eta(in_eta),
    .in_charge_positive(in_charge_positive),
    .in_bin_index(in_bin_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_bin_valid(out_bin_valid),
    .out_mean_multiplicity(out_mean_multiplicity),
    .out_mean_net_charge(out_mean_net_charge),
    .out_event_count(out_event_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("binned_net_charge_mean_top test failed");
      $finish;
    end
  end

  function automatic void profile_apply(logic [1:0] m, logic [PT_W-1:0] p,
                                        logic signed [ETA_W-1:0] e, logic c,
                                        logic [BIN_IN_W-1:0] bi, bit zero_exp);
    int ae;
    int unsigned b;
    int unsigned lim;
    logic [63:0] mm;
    logic [63:0] mag;
    logic [63:0] q;
    bin_means_t r;
    ae = e;
    if (ae < 0) ae = -ae;
    case (m)
      MODE_TRACK: begin
        if (trk_cnt != TC_W'(MAX_TRACKS)) begin
          trk_cnt++;
          if (p > pt_thr && ae < int'(eta_lim)) evt_charge += c ? 1 : -1;
        end
      end
      MODE_EOE: begin
        lim = int'(bin_wd) * (NUM_BINS - 1);
        if (int'(trk_cnt) < lim) b = int'(trk_cnt) / int'(bin_wd);
        else b = NUM_BINS - 1;
        if (bin_ev[b] != '1) begin
          bin_ev[b]++;
          bin_trk[b] += 64'(trk_cnt);
          bin_chg[b] += longint'(evt_charge);
        end
        trk_cnt = '0;
        evt_charge = 0;
      end
      MODE_READ: begin
        r = '0;
        if (!zero_exp && int'(bi) < NUM_BINS && bin_ev[bi] != 0) begin
          mm = (bin_trk[bi] << 8) / 64'(bin_ev[bi]);
          mag = (bin_chg[bi] < 0) ? 64'(-bin_chg[bi]) : 64'(bin_chg[bi]);
          q = (mag << 8) / 64'(bin_ev[bi]);
          if (bin_chg[bi] < 0) q = -q;
          r.bin_valid = 1'b1;
          r.mean_mult = mm[Q_W-1:0];
          r.mean_charge = q[NC_W-1:0];
          r.events = bin_ev[bi];
        end
        pending_means.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // result channel: random or long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req > 0) begin
      out_stall = 1'b1;
      hold_left = hold_req - 1;
      hold_req = 0;
    end else begin
      out_stall = rst_n && ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    bin_means_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word: events %0d", out_event_count);
      end else begin
        want = pending_means.pop_front();
        if (want.bin_valid !== out_bin_valid || want.mean_mult !== out_mean_multiplicity ||
            want.mean_charge !== out_mean_net_charge || want.events !== out_event_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch exp/act: valid %0d/%0d mult %0d/%0d charge %0d/%0d ev %0d/%0d",
                     want.bin_valid, out_bin_valid, want.mean_mult, out_mean_multiplicity,
                     $signed(want.mean_charge), out_mean_net_charge,
                     want.events, out_event_count);
        end
      end
    end
  end

  task automatic send_word(logic [1:0] m, logic [PT_W-1:0] p, logic signed [ETA_W-1:0] e,
                           logic c, logic [BIN_IN_W-1:0] bi, bit zero_exp);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < snd_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_pt = p;
    in_eta = e;
    in_charge_positive = c;
    in_bin_index = bi;
    do @(posedge clk); while (in_stall);
    profile_apply(m, p, e, c, bi, zero_exp);
  endtask

  task automatic send_read(logic [BIN_IN_W-1:0] bi);
    send_word(MODE_READ, PT_W'($urandom), ETA_W'($urandom), 1'($urandom), bi, 1'b0);
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain_results();
    // an end of event may still be updating a bin
    repeat (48) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_PT_THR:  pt_thr = val[PT_W-1:0];
      CFG_ETA_LIM: eta_lim = val[ETAL_W-1:0];
      CFG_BIN_W:   bin_wd = val[BW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_profile(int pt_v, int eta_v, int bw_v);
    set_register(CFG_PT_THR, CFG_W'(pt_v));
    set_register(CFG_ETA_LIM, CFG_W'(eta_v));
    set_register(CFG_BIN_W, CFG_W'(bw_v));
  endtask

  // one event past the track cap, then read the bin it lands in
  task automatic overflow_event(logic c, logic [BIN_IN_W-1:0] bi);
    int k;
    for (k = 0; k < 270; k++)
      send_word(MODE_TRACK, 16'd60000, ETA_W'(int'($urandom_range(0, 1000)) - 500), c,
                BIN_IN_W'($urandom), 1'b0);
    send_word(MODE_EOE, PT_W'($urandom), ETA_W'($urandom), 1'($urandom), 3'd0, 1'b0);
    send_read(bi);
  endtask

  task automatic run_random(int n);
    int done;
    int sz;
    int k;
    int t;
    logic [PT_W-1:0] p;
    logic signed [ETA_W-1:0] e;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 12) sz = $urandom_range(20, 140);
      else sz = $urandom_range(0, 24);
      for (k = 0; k < sz; k++) begin
        case ($urandom_range(0, 3))
          0: p = PT_W'($urandom);
          1: begin
            t = int'(pt_thr) + int'($urandom_range(0, 2)) - 1;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            p = PT_W'(t);
          end
          2: p = $urandom_range(0, 1) ? '1 : '0;
          default: p = PT_W'($urandom_range(0, 200));
        endcase
        case ($urandom_range(0, 2))
          0: e = ETA_W'($urandom);
          1: begin
            t = int'(eta_lim) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1)) t = -t;
            e = ETA_W'(t);
          end
          default: e = ETA_W'(int'($urandom_range(0, 2048)) - 1024);
        endcase
        send_word(MODE_TRACK, p, e, 1'($urandom), BIN_IN_W'($urandom), 1'b0);
        done++;
        if ($urandom_range(0, 99) < 2)
          send_word(MODE_UNUSED, PT_W'($urandom), ETA_W'($urandom), 1'($urandom),
                    BIN_IN_W'($urandom), 1'b0);
        if ($urandom_range(0, 199) == 0) begin
          send_read(BIN_IN_W'($urandom));
          done++;
        end
      end
      // a few events run into the next one without an end marker
      if ($urandom_range(0, 99) >= 3) begin
        send_word(MODE_EOE, PT_W'($urandom), ETA_W'($urandom), 1'($urandom),
                  BIN_IN_W'($urandom), 1'b0);
        done++;
      end
      if ($urandom_range(0, 99) < 45) begin
        send_read(BIN_IN_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_BINS; i++) begin
      bin_ev[i] = '0;
      bin_trk[i] = '0;
      bin_chg[i] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    snd_idle_pct = 17;
    rcv_idle_pct = 66;
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd0, 1'b1});
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd5, 1'b1});
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd6, 1'b1});
    dir_rows.push_back('{MODE_READ,   16'hFFFF,  -14'sd1,    1'b1, 3'd7, 1'b1});
    dir_rows.push_back('{MODE_UNUSED, 16'hFFFF,  -14'sd1,    1'b1, 3'd7, 1'b0});
    dir_rows.push_back('{MODE_EOE,    16'd0,     14'sd0,     1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'hFFFF,  14'sd0,     1'b1, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd0,     -14'sd8192, 1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd51,    14'sd1023,  1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd50,    14'sd0,     1'b1, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd100,   -14'sd1024, 1'b1, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd100,   14'sd8191,  1'b1, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_TRACK,  16'd100,   -14'sd1023, 1'b1, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_EOE,    16'd0,     14'sd0,     1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd0, 1'b0});
    dir_rows.push_back('{MODE_READ,   16'd0,     14'sd0,     1'b0, 3'd1, 1'b1});
    foreach (dir_rows[i])
      send_word(dir_rows[i].mode, dir_rows[i].pt, dir_rows[i].eta, dir_rows[i].chg,
                dir_rows[i].bidx, dir_rows[i].zero_exp);

    // full event at the track cap, all positive, into the top bin
    overflow_event(1'b1, 3'd5);
    run_random(150);

    set_profile(0, 8191, 1);
    snd_idle_pct = 66;
    rcv_idle_pct = 17;
    run_random(80);
    hold_req = 400;
    for (i = 0; i < 6; i++) send_read(BIN_IN_W'($urandom_range(0, 5)));
    run_random(80);

    set_profile(0, 8191, 255);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // capped event of negative tracks, into bin 1
    overflow_event(1'b0, 3'd1);
    run_random(100);

    // zero bin width sends every event to the top bin
    set_profile(65535, 0, 0);
    run_random(40);
    drain_results();
    run_random(40);

    set_profile($urandom_range(0, 400), $urandom_range(0, 3000), $urandom_range(1, 40));
    run_random(100);

    drain_results();
    repeat (60) @(posedge clk);
    fail_count += pending_means.size();
    if (fail_count == 0) begin
      $display("binned_net_charge_mean_top test passed");
    end else begin
      $display("binned_net_charge_mean_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
